@@ src/sbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and constants of the spectral bin limiter
// Register indexes, pipeline payload types, log and exp2 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] REG_LIMIT_ENABLE   = 8'd0;
  localparam logic [7:0] REG_LEVEL_OFFSET   = 8'd1;
  localparam logic [7:0] REG_THRESH_FLOOR   = 8'd2;
  localparam logic [7:0] REG_THRESH_CEILING = 8'd3;

  localparam logic        RST_LIMIT_ENABLE   = 1'b1;
  localparam logic [15:0] RST_LEVEL_OFFSET   = 16'hD000;
  localparam logic [15:0] RST_THRESH_FLOOR   = 16'hA600;
  localparam logic [15:0] RST_THRESH_CEILING = 16'h0000;

  // 2560*log10(2) in Q16
  localparam logic signed [26:0] LOG_K      = 27'sd50504453;
  localparam logic signed [17:0] ZERO_LEVEL = -18'sd51200;

  typedef struct packed {
    logic               enable;
    logic signed [15:0] offset;
    logic signed [15:0] floor;
    logic signed [15:0] ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [15:0] thr;
    logic               last;
  } carry_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [6:0]         q;
    logic [15:0]        f;
    logic               lim;
    logic               last;
  } work_t;

  typedef logic [15:0][31:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    rem  = v;
    for (int k = 0; k < 32; k++) begin
      if (bitv > rem) begin
        bitv = bitv >> 2;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (bitv != '0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // factor j holds 2^(-2^-(j+1)) in Q32
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 0; j < 16; j++) begin
      c = isqrt64(c << 32);
      tab[j] = c[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

endpackage

`default_nettype wire

@@ src/sbl_front.sv @@
// ----------------------------------------------------------------------------
// sbl_front: level measurement and classification
// Power, log2, dB level, excess over the clamped threshold, split of the excess.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sbl_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] in_re_i,
  input  wire logic signed [31:0] in_im_i,
  input  wire logic signed [15:0] in_thr_i,
  input  wire logic               in_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sbl_pkg::work_t          out_data_o
);

  logic en;

  // input stage
  logic               v0_q;
  sbl_pkg::carry_t    c0_q;
  logic signed [15:0] thr_lo;
  logic signed [15:0] thr_cl;

  always_comb begin
    thr_lo = (in_thr_i < cfg_i.floor) ? cfg_i.floor : in_thr_i;
    thr_cl = (thr_lo > cfg_i.ceiling) ? cfg_i.ceiling : thr_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q <= '{re: in_re_i, im: in_im_i, thr: thr_cl, last: in_last_i};
    end
  end

  // squares
  logic            v1_q;
  sbl_pkg::carry_t c1_q;
  logic [31:0]     ar;
  logic [31:0]     ai;
  logic [63:0]     pr_q;
  logic [63:0]     pi_q;

  assign ar = c0_q.re[31] ? 32'(-c0_q.re) : 32'(c0_q.re);
  assign ai = c0_q.im[31] ? 32'(-c0_q.im) : 32'(c0_q.im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= c0_q;
      pr_q <= 64'(ar) * 64'(ar);
      pi_q <= 64'(ai) * 64'(ai);
    end
  end

  // power and normalize
  logic [63:0]     nx_q  [4];
  logic [5:0]      nsh_q [4];
  logic            nz_q  [4];
  sbl_pkg::carry_t nc_q  [4];
  logic            nv_q  [4];
  logic [63:0]     psum;

  assign psum = pr_q + pi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q[0] <= 1'b0;
    end else if (en) begin
      nv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q[0]  <= psum;
      nsh_q[0] <= '0;
      nz_q[0]  <= (psum == '0);
      nc_q[0]  <= c1_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_norm
    localparam int Big   = 32 >> (2 * g);
    localparam int Small = 16 >> (2 * g);
    logic [63:0] x;
    logic [5:0]  s;

    always_comb begin
      x = nx_q[g];
      s = nsh_q[g];
      if (x[63 -: Big] == '0) begin
        x = x << Big;
        s = s + 6'(Big);
      end
      if (x[63 -: Small] == '0) begin
        x = x << Small;
        s = s + 6'(Small);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[g+1] <= 1'b0;
      end else if (en) begin
        nv_q[g+1] <= nv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        nx_q[g+1]  <= x;
        nsh_q[g+1] <= s;
        nz_q[g+1]  <= nz_q[g];
        nc_q[g+1]  <= nc_q[g];
      end
    end
  end

  // log2 fraction by repeated squaring
  logic [31:0]     ly_q  [17];
  logic [15:0]     lfr_q [17];
  logic [5:0]      ln_q  [17];
  logic            lz_q  [17];
  sbl_pkg::carry_t lc_q  [17];
  logic            lv_q  [17];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q[0] <= 1'b0;
    end else if (en) begin
      lv_q[0] <= nv_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ly_q[0]  <= nx_q[3][63:32];
      lfr_q[0] <= '0;
      ln_q[0]  <= 6'd63 - nsh_q[3];
      lz_q[0]  <= nz_q[3];
      lc_q[0]  <= nc_q[3];
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] y2;
    logic [31:0] y_n;
    logic [15:0] fr_n;

    always_comb begin
      sq   = 64'(ly_q[i]) * 64'(ly_q[i]);
      y2   = sq[63:31];
      y_n  = y2[32] ? y2[32:1] : y2[31:0];
      fr_n = lfr_q[i];
      fr_n[15-i] = y2[32];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv_q[i+1] <= 1'b0;
      end else if (en) begin
        lv_q[i+1] <= lv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ly_q[i+1]  <= y_n;
        lfr_q[i+1] <= fr_n;
        ln_q[i+1]  <= ln_q[i];
        lz_q[i+1]  <= lz_q[i];
        lc_q[i+1]  <= lc_q[i];
      end
    end
  end

  // dB level, excess, split of the excess
  logic               va_q, vb_q, vc_q, vd_q;
  logic signed [49:0] prod_q;
  logic               za_q;
  sbl_pkg::carry_t    ca_q, cb_q, cc_q;
  logic signed [22:0] t;
  logic signed [49:0] rnd;
  logic signed [17:0] lvl;
  logic signed [18:0] e_d;
  logic signed [18:0] e_q;
  logic [7:0]         n9;
  logic [16:0]        qm;
  logic [6:0]         q_d;
  logic [7:0]         rn;
  logic [6:0]         q_q;
  logic [10:0]        r_q;
  logic               lim_q;
  logic [20:0]        r3m;
  logic [9:0]         r3;
  logic [10:0]        rm;
  logic [15:0]        f_d;
  sbl_pkg::work_t     w_q;

  always_comb begin
    t   = $signed({1'b0, ln_q[16], lfr_q[16]}) - 23'sd2097152;
    rnd = prod_q + 50'sd2147483648;
    lvl = za_q ? sbl_pkg::ZERO_LEVEL : rnd[49:32];
    e_d = 19'(lvl) + 19'(cfg_i.offset) - 19'(ca_q.thr);
    n9  = e_q[16:9];
    qm  = 17'(n9) * 17'd171;
    q_d = qm[15:9];
    rn  = n9 - 8'({q_d, 1'b0} + {1'b0, q_d});
    r3m = 21'(r_q) * 21'd683;
    r3  = r3m[20:11];
    rm  = r_q - 11'({r3, 1'b0} + {1'b0, r3});
    f_d = {r3[8:0], 7'b0};
    if (rm[1:0] == 2'd1) begin
      f_d = f_d + 16'd42;
    end else if (rm[1:0] == 2'd2) begin
      f_d = f_d + 16'd85;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= lv_q[16];
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 50'(t) * 50'(sbl_pkg::LOG_K);
      za_q   <= lz_q[16];
      ca_q   <= lc_q[16];
      e_q    <= e_d;
      cb_q   <= ca_q;
      q_q    <= q_d;
      r_q    <= {rn[1:0], e_q[8:0]};
      lim_q  <= cfg_i.enable && (e_q > 19'sd0);
      cc_q   <= cb_q;
      w_q    <= '{re: cc_q.re, im: cc_q.im, q: q_q, f: f_d, lim: lim_q, last: cc_q.last};
    end
  end

  assign en          = !vd_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vd_q;
  assign out_data_o  = w_q;

endmodule

`default_nettype wire

@@ src/sbl_fifo.sv @@
// ----------------------------------------------------------------------------
// sbl_fifo: queue between classification and scaling
// Small register queue; either side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_fifo #(
  parameter int Depth = sbl_pkg::FIFO_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sbl_pkg::work_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output sbl_pkg::work_t      data_o,
  output logic                empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sbl_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= bump(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= bump(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (rptr_q == wptr_q)) else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

@@ src/sbl_back.sv @@
// ----------------------------------------------------------------------------
// sbl_back: gain computation and scaling
// Builds 2^(-f) from a factor table, scales both parts, rounds and shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_empty_i,
  input  wire sbl_pkg::work_t in_data_i,
  output logic                in_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         out_re_o,
  output logic [31:0]         out_im_o,
  output logic                out_lim_o,
  output logic                out_last_o
);

  logic en;

  logic [32:0]    xm_q [17];
  sbl_pkg::work_t xw_q [17];
  logic           xv_q [17];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q[0] <= 1'b0;
    end else if (en) begin
      xv_q[0] <= !in_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xm_q[0] <= 33'h1_0000_0000;
      xw_q[0] <= in_data_i;
    end
  end

  for (genvar j = 0; j < 16; j++) begin : g_exp
    logic [64:0] pm;
    assign pm = 65'(xm_q[j]) * 65'(sbl_pkg::EXP_C[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        xv_q[j+1] <= 1'b0;
      end else if (en) begin
        xv_q[j+1] <= xv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        xm_q[j+1] <= xw_q[j].f[15-j] ? pm[64:32] : xm_q[j];
        xw_q[j+1] <= xw_q[j];
      end
    end
  end

  // products
  logic           vm_q;
  sbl_pkg::work_t wm_q;
  logic [64:0]    pre_q, pim_q;
  logic [31:0]    mre, mim;

  assign mre = xw_q[16].re[31] ? 32'(-xw_q[16].re) : 32'(xw_q[16].re);
  assign mim = xw_q[16].im[31] ? 32'(-xw_q[16].im) : 32'(xw_q[16].im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= xv_q[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wm_q  <= xw_q[16];
      pre_q <= 65'(mre) * 65'(xm_q[16]);
      pim_q <= 65'(mim) * 65'(xm_q[16]);
    end
  end

  function automatic logic [31:0] round_part(logic [64:0] pm, logic neg, logic [6:0] q);
    logic [65:0] sum;
    logic [65:0] sh;
    logic [31:0] r;
    r = '0;
    if (q < 7'd32) begin
      sum = {1'b0, pm} + (66'd1 << (7'd31 + q));
      sh  = sum >> (7'd32 + q);
      r   = sh[31:0];
    end
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  // output register
  logic        vo_q;
  logic [31:0] re_q, im_q;
  logic        lim_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q   <= wm_q.lim ? round_part(pre_q, wm_q.re[31], wm_q.q) : 32'(wm_q.re);
      im_q   <= wm_q.lim ? round_part(pim_q, wm_q.im[31], wm_q.q) : 32'(wm_q.im);
      lim_q  <= wm_q.lim;
      last_q <= wm_q.last;
    end
  end

  assign en          = !vo_q || out_ready_i;
  assign in_pop_o    = en && !in_empty_i;
  assign out_valid_o = vo_q;
  assign out_re_o    = re_q;
  assign out_im_o    = im_q;
  assign out_lim_o   = lim_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

@@ src/spectral_bin_limiter.sv @@
// ----------------------------------------------------------------------------
// spectral_bin_limiter: per-bin spectral limiter
// Measures each bin's level in dB and scales bins above their threshold.
// ----------------------------------------------------------------------------
// One bin enters per clock and one result leaves per clock while both sides
// keep up. A bin's result is offered when the bin has passed 47 register
// stages, the first loaded at the transfer itself. 27 are in the measuring
// pipeline (input, squares, normalize, 16 squaring rounds of the log2,
// level and excess), one is the queue and 19 are in the scaling pipeline
// (entry, 16 gain factor stages, product and rounding). The queue lets the
// input keep moving for a few bins while the output is stalled. Configuration
// writes are taken at any time and should be made with no bins in flight.
`default_nettype none

module spectral_bin_limiter #(
  parameter int FifoDepth = sbl_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // bin_real[31:0], bin_imag[63:32], bin_threshold[79:64]
  input  wire logic [79:0] s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_real[31:0], out_imag[63:32]
  output logic [63:0]      m_axis_tdata_o,
  // was_limited[0]
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  sbl_pkg::cfg_t  cfg_q;
  sbl_pkg::work_t fq_din, fq_dout;
  logic           fq_push, fq_full, fq_pop, fq_empty;
  logic           fr_valid;
  logic [31:0]    bk_re, bk_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable  <= sbl_pkg::RST_LIMIT_ENABLE;
      cfg_q.offset  <= $signed(sbl_pkg::RST_LEVEL_OFFSET);
      cfg_q.floor   <= $signed(sbl_pkg::RST_THRESH_FLOOR);
      cfg_q.ceiling <= $signed(sbl_pkg::RST_THRESH_CEILING);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbl_pkg::REG_LIMIT_ENABLE:   cfg_q.enable  <= cfg_data_i[0];
        sbl_pkg::REG_LEVEL_OFFSET:   cfg_q.offset  <= $signed(cfg_data_i);
        sbl_pkg::REG_THRESH_FLOOR:   cfg_q.floor   <= $signed(cfg_data_i);
        sbl_pkg::REG_THRESH_CEILING: cfg_q.ceiling <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  sbl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_re_i     ($signed(s_axis_tdata_i[31:0])),
    .in_im_i     ($signed(s_axis_tdata_i[63:32])),
    .in_thr_i    ($signed(s_axis_tdata_i[79:64])),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (fr_valid),
    .out_ready_i (!fq_full),
    .out_data_o  (fq_din)
  );

  assign fq_push = fr_valid && !fq_full;

  sbl_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_din),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_dout),
    .empty_o (fq_empty)
  );

  sbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_empty_i  (fq_empty),
    .in_data_i   (fq_dout),
    .in_pop_o    (fq_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_re_o    (bk_re),
    .out_im_o    (bk_im),
    .out_lim_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {bk_im, bk_re};

endmodule

`default_nettype wire
